@@ hdl/bdd_pkg.sv @@
package bdd_pkg;

    localparam int VALUE_W = 16;
    localparam int INDEX_W = 16;
    localparam int RATIO_W = 5;
    localparam int BAUD_W  = 27;
    localparam int SPEED_W = 31;
    localparam int PROD_W  = BAUD_W + RATIO_W;

    // Dividend and divisor widths of the restoring divider.
    localparam int NUM_W = 28;
    localparam int DIV_W = 18;

    localparam int INT_W  = 14;
    localparam int FRAC_W = 3;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_RATIO_BASE = 1'b0;
    localparam logic REG_RATIO_FAST = 1'b1;

    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(1);

    localparam logic [NUM_W-1:0] CLK_FAST = NUM_W'(12000000);
    localparam logic [NUM_W-1:0] CLK_BASE = NUM_W'(3000000);

    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

    typedef struct packed {
        logic             acc;
        logic             fast;
        logic [DIV_W-1:0] rem;
        logic [NUM_W-1:0] nq;
        logic [DIV_W-1:0] dvsr;
    } div_item_t;

    // Fraction code to eighths.
    function automatic logic [FRAC_W-1:0] frac_eighths(input logic [FRAC_W-1:0] code);
        logic [FRAC_W-1:0] f;
        case (code)
            3'd0:    f = 3'd0;
            3'd1:    f = 3'd4;
            3'd2:    f = 3'd2;
            3'd3:    f = 3'd1;
            3'd4:    f = 3'd3;
            3'd5:    f = 3'd5;
            3'd6:    f = 3'd6;
            default: f = 3'd7;
        endcase
        return f;
    endfunction

endpackage

@@ hdl/bdd_prep.sv @@
module bdd_prep (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bdd_pkg::VALUE_W-1:0]   value_word,
    input  logic [bdd_pkg::INDEX_W-1:0]   index_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bdd_pkg::div_item_t            out_item
);
    import bdd_pkg::*;

    logic              valid_reg;
    div_item_t         item_reg;
    div_item_t         item_next;
    logic              iface_ok;
    logic              fast;
    logic [INT_W-1:0]  n;
    logic [FRAC_W-1:0] f;
    logic [NUM_W-1:0]  clk_sel;
    logic [DIV_W-2:0]  den;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        iface_ok = (index_word[7:1] == 7'd0);
        fast     = index_word[9];
        n        = value_word[INT_W-1:0];
        f        = frac_eighths({index_word[8], value_word[15:14]});
        clk_sel  = fast ? CLK_FAST : CLK_BASE;
        // 8n + f is a plain concatenation because f stays below eight.
        den      = {n, f};

        item_next.acc  = iface_ok;
        item_next.fast = iface_ok && fast;
        item_next.rem  = '0;
        if (!iface_ok)
        begin
            item_next.nq   = '0;
            item_next.dvsr = DIV_W'(1);
        end
        else if (f == '0 && n == INT_W'(0))
        begin
            item_next.nq   = {clk_sel[NUM_W-2:0], 1'b0};
            item_next.dvsr = DIV_W'(2);
        end
        else if (f == '0 && n == INT_W'(1))
        begin
            item_next.nq   = {clk_sel[NUM_W-2:0], 1'b0};
            item_next.dvsr = DIV_W'(3);
        end
        else if (f == '0 && n == INT_W'(2))
        begin
            item_next.nq   = clk_sel;
            item_next.dvsr = DIV_W'(2);
        end
        else
        begin
            // Adding the divisor once more before halving gives round half up.
            item_next.nq   = {clk_sel[NUM_W-5:0], 4'b0} + NUM_W'(den);
            item_next.dvsr = {den, 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ hdl/bdd_div_cell.sv @@
module bdd_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bdd_pkg::div_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output bdd_pkg::div_item_t out_item
);
    import bdd_pkg::*;

    logic             valid_reg;
    div_item_t        item_reg;
    div_item_t        item_next;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             q_bit;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // One restoring step: the dividend bit shifts out the top of nq and the
    // quotient bit shifts in at the bottom.
    always_comb
    begin
        shifted   = {in_item.rem, in_item.nq[NUM_W-1]};
        diff      = shifted - {1'b0, in_item.dvsr};
        q_bit     = !diff[DIV_W];
        item_next = in_item;
        item_next.rem = q_bit ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        item_next.nq  = {in_item.nq[NUM_W-2:0], q_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ hdl/bdd_scale.sv @@
module bdd_scale (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  bdd_pkg::div_item_t           in_item,
    input  logic [bdd_pkg::RATIO_W-1:0]  ratio_base,
    input  logic [bdd_pkg::RATIO_W-1:0]  ratio_fast,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         accepted,
    output logic                         fast_clock,
    output logic [bdd_pkg::BAUD_W-1:0]   baud_rate,
    output logic [bdd_pkg::SPEED_W-1:0]  bitbang_speed
);
    import bdd_pkg::*;

    logic               valid_reg;
    logic               acc_reg;
    logic               fast_reg;
    logic [BAUD_W-1:0]  baud_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [BAUD_W-1:0]  baud;
    logic [RATIO_W-1:0] ratio;
    logic [PROD_W-1:0]  product;
    logic [SPEED_W-1:0] speed_next;

    assign in_ready      = !valid_reg || out_ready;
    assign out_valid     = valid_reg;
    assign accepted      = acc_reg;
    assign fast_clock    = fast_reg;
    assign baud_rate     = baud_reg;
    assign bitbang_speed = speed_reg;

    always_comb
    begin
        baud       = in_item.nq[BAUD_W-1:0];
        ratio      = in_item.fast ? ratio_fast : ratio_base;
        product    = {{RATIO_W{1'b0}}, baud} * {{BAUD_W{1'b0}}, ratio};
        speed_next = product[PROD_W-1] ? SPEED_MAX : product[SPEED_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            acc_reg   <= in_item.acc;
            fast_reg  <= in_item.fast;
            baud_reg  <= baud;
            speed_reg <= speed_next;
        end
    end

endmodule

@@ hdl/baud_divisor_decoder.sv @@
// Channel   Handshake                        Beat contents
// req       req_valid / req_ready            value_word, index_word
// rsp       rsp_valid / rsp_ready            accepted, fast_clock, baud_rate, bitbang_speed
// cfg       psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// A request passes from accepted beat to result through one decode stage, a chain
// of 28 restoring divider cells (one quotient bit each), and one multiply stage.
// A new request can enter every cycle unless a stalled result has backed up the stages.
// Each stage holds its beat while the next one is full, so a stalled result
// only stops the stages behind it once they fill up.
// Reset clears all stage valid flags and sets both ratio registers to 1.
module baud_divisor_decoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic [bdd_pkg::VALUE_W-1:0]  value_word,
    input  logic [bdd_pkg::INDEX_W-1:0]  index_word,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic                         accepted,
    output logic                         fast_clock,
    output logic [bdd_pkg::BAUD_W-1:0]   baud_rate,
    output logic [bdd_pkg::SPEED_W-1:0]  bitbang_speed,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bdd_pkg::ADDR_W-1:0]   paddr,
    input  logic [bdd_pkg::DATA_W-1:0]   pwdata,
    output logic [bdd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import bdd_pkg::*;

    logic [RATIO_W-1:0] ratio_base_reg;
    logic [RATIO_W-1:0] ratio_fast_reg;
    logic               reg_sel;

    div_item_t          link_item  [0:NUM_W];
    logic               link_valid [0:NUM_W];
    logic               link_ready [0:NUM_W];

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_comb
    begin
        unique case (reg_sel)
            REG_RATIO_BASE: prdata = DATA_W'(ratio_base_reg);
            REG_RATIO_FAST: prdata = DATA_W'(ratio_fast_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_base_reg <= RATIO_RESET;
            ratio_fast_reg <= RATIO_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (reg_sel == REG_RATIO_BASE)
            begin
                ratio_base_reg <= pwdata[RATIO_W-1:0];
            end
            else
            begin
                ratio_fast_reg <= pwdata[RATIO_W-1:0];
            end
        end
    end

    bdd_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req_valid),
        .in_ready   (req_ready),
        .value_word (value_word),
        .index_word (index_word),
        .out_valid  (link_valid[0]),
        .out_ready  (link_ready[0]),
        .out_item   (link_item[0])
    );

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_cell
        bdd_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_item   (link_item[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_item  (link_item[i+1])
        );
    end

    bdd_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (link_valid[NUM_W]),
        .in_ready      (link_ready[NUM_W]),
        .in_item       (link_item[NUM_W]),
        .ratio_base    (ratio_base_reg),
        .ratio_fast    (ratio_fast_reg),
        .out_valid     (rsp_valid),
        .out_ready     (rsp_ready),
        .accepted      (accepted),
        .fast_clock    (fast_clock),
        .baud_rate     (baud_rate),
        .bitbang_speed (bitbang_speed)
    );

endmodule

@@ hdl/bdd_checker.sv @@
module bdd_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rsp_valid,
    input  logic                         rsp_ready,
    input  logic                         accepted,
    input  logic                         fast_clock,
    input  logic [bdd_pkg::BAUD_W-1:0]   baud_rate,
    input  logic [bdd_pkg::SPEED_W-1:0]  bitbang_speed
);
    import bdd_pkg::*;

    // A result beat that is not taken stays put.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(baud_rate)
            && $stable(bitbang_speed) && $stable(accepted) && $stable(fast_clock))
        else $error("result beat changed while stalled");

    // A rejected request carries nothing but zeros.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !accepted |-> !fast_clock && baud_rate == '0 && bitbang_speed == '0)
        else $error("rejected request with nonzero fields");

    // The fastest rate is half of sixteen times the 12 MHz clock.
    a_baud_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> baud_rate <= BAUD_W'(96000000))
        else $error("baud rate above the 12 MHz ceiling");

    // The slow clock can never produce more than 24 Mbaud.
    a_base_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !fast_clock |-> baud_rate <= BAUD_W'(24000000))
        else $error("baud rate above the 3 MHz ceiling");

    // Speed is a multiple of baud, so a zero rate gives a zero speed.
    a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && baud_rate == '0 |-> bitbang_speed == '0)
        else $error("nonzero speed from zero baud rate");

endmodule

bind baud_divisor_decoder bdd_checker u_bdd_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;

    import bdd_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_RATIO_BASE = {REG_RATIO_BASE, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_RATIO_FAST = {REG_RATIO_FAST, 2'b00};

    localparam int NUM_PHASES     = 8;
    localparam int BEATS_PER_PHASE = 204;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PROBES     = 22;

    typedef struct packed {
        logic               acc;
        logic               fast;
        logic [BAUD_W-1:0]  baud;
        logic [SPEED_W-1:0] speed;
    } rate_beat_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        logic               typed;
        rate_beat_t         result;
    } probe_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    logic [VALUE_W-1:0]  value_word;
    logic [INDEX_W-1:0]  index_word;
    logic                rsp_valid;
    logic                rsp_ready;
    logic                accepted;
    logic                fast_clock;
    logic [BAUD_W-1:0]   baud_rate;
    logic [SPEED_W-1:0]  bitbang_speed;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    rate_beat_t          pending_rates [$];
    logic [RATIO_W-1:0]  shadow_ratio_base;
    logic [RATIO_W-1:0]  shadow_ratio_fast;
    int                  fail_count = 0;
    int                  idle_cycles = 0;
    bit                  no_idle = 1'b0;
    bit                  hold_pending = 1'b0;

    // Rows with a typed result are read straight off the decode rules at reset ratios.
    probe_row_t probes [NUM_PROBES] = '{
        '{16'h0000, 16'h0000, 1'b1, '{1'b1, 1'b0, 27'd3000000,  31'd3000000}},
        '{16'h0000, 16'h0200, 1'b1, '{1'b1, 1'b1, 27'd12000000, 31'd12000000}},
        '{16'h0001, 16'h0201, 1'b1, '{1'b1, 1'b1, 27'd8000000,  31'd8000000}},
        '{16'h0002, 16'h0200, 1'b1, '{1'b1, 1'b1, 27'd6000000,  31'd6000000}},
        '{16'h0001, 16'h0000, 1'b1, '{1'b1, 1'b0, 27'd2000000,  31'd2000000}},
        '{16'h0002, 16'h0001, 1'b1, '{1'b1, 1'b0, 27'd1500000,  31'd1500000}},
        '{16'h0003, 16'h0000, 1'b1, '{1'b1, 1'b0, 27'd1000000,  31'd1000000}},
        '{16'hFFFF, 16'h0002, 1'b1, '0},
        '{16'h0000, 16'hFFFF, 1'b1, '0},
        '{16'hC000, 16'h0302, 1'b1, '0},
        '{16'hC000, 16'h0200, 1'b1, '{1'b1, 1'b1, 27'd96000000, 31'd96000000}},
        '{16'hC000, 16'h0000, 1'b1, '{1'b1, 1'b0, 27'd24000000, 31'd24000000}},
        '{16'h3FFF, 16'h0200, 1'b0, '0},
        '{16'h3FFF, 16'h0001, 1'b0, '0},
        '{16'h4000, 16'h0200, 1'b0, '0},
        '{16'h8000, 16'h0001, 1'b0, '0},
        '{16'h0000, 16'h0100, 1'b0, '0},
        '{16'h4005, 16'h0101, 1'b0, '0},
        '{16'h8007, 16'h0300, 1'b0, '0},
        '{16'hFFFF, 16'h0301, 1'b0, '0},
        '{16'h0123, 16'hFE01, 1'b0, '0},
        '{16'h5A5A, 16'hFD00, 1'b0, '0}
    };

    baud_divisor_decoder u_top (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic rate_beat_t predict_rate(input logic [VALUE_W-1:0] value,
                                                input logic [INDEX_W-1:0] index);
        rate_beat_t   beat;
        logic [63:0]  clk_hz;
        logic [63:0]  whole;
        logic [63:0]  eighths;
        logic [63:0]  den;
        logic [63:0]  rate;
        logic [63:0]  product;
        logic [2:0]   code;
        beat = '0;
        if (index[7:0] > 8'd1)
            return beat;
        beat.acc  = 1'b1;
        beat.fast = index[9];
        clk_hz = index[9] ? 64'd12000000 : 64'd3000000;
        whole  = 64'(value[13:0]);
        code   = {index[8], value[15:14]};
        case (code)
            3'd0:    eighths = 64'd0;
            3'd1:    eighths = 64'd4;
            3'd2:    eighths = 64'd2;
            3'd3:    eighths = 64'd1;
            3'd4:    eighths = 64'd3;
            3'd5:    eighths = 64'd5;
            3'd6:    eighths = 64'd6;
            default: eighths = 64'd7;
        endcase
        // Small whole divisors with no fraction are read as 1, 1.5 and 2.
        if (eighths == 0 && whole < 3)
        begin
            if (whole == 0)
                rate = clk_hz;
            else if (whole == 1)
                rate = (clk_hz * 2) / 3;
            else
                rate = clk_hz / 2;
        end
        else
        begin
            den  = 8 * whole + eighths;
            rate = (clk_hz * 16 + den) / (2 * den);
        end
        product = rate * 64'(index[9] ? shadow_ratio_fast : shadow_ratio_base);
        if (product > 64'h7FFF_FFFF)
            product = 64'h7FFF_FFFF;
        beat.baud  = rate[BAUD_W-1:0];
        beat.speed = product[SPEED_W-1:0];
        return beat;
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 19));
    endfunction

    task automatic send_request(input logic [VALUE_W-1:0] value,
                                input logic [INDEX_W-1:0] index,
                                input logic typed, input rate_beat_t typed_result);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid  <= 1'b1;
        value_word <= value;
        index_word <= index;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_rates.push_back(typed ? typed_result : predict_rate(value, index));
    endtask

    task automatic send_random_request();
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        value = VALUE_W'($urandom);
        index = INDEX_W'($urandom);
        if ($urandom_range(0, 7) == 0)
            index[7:0] = 8'($urandom_range(2, 255));
        else
            index[7:0] = 8'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0:       value[13:0] = 14'($urandom_range(0, 3));
            1:       value[13:0] = 14'($urandom_range(1, 16));
            default: ;
        endcase
        send_request(value, index, 1'b0, '0);
    endtask

    // Writes a ratio register, then reads it back.
    task automatic write_ratio(input logic [ADDR_W-1:0] addr, input logic [RATIO_W-1:0] ratio);
        logic [DATA_W-1:0] data;
        data = DATA_W'($urandom);
        data[RATIO_W-1:0] = ratio;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == ADDR_RATIO_BASE)
            shadow_ratio_base = ratio;
        else
            shadow_ratio_fast = ratio;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== DATA_W'(ratio))
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("ratio readback at %0d: expected %0d, got %0d", addr, ratio, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_drain();
        while (pending_rates.size() != 0)
            @(posedge clk);
    endtask

    // Receiver side: random stalls, plus one long hold when asked.
    initial
    begin
        int         gap;
        rate_beat_t got;
        rate_beat_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap();
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            got = '{accepted, fast_clock, baud_rate, bitbang_speed};
            if (pending_rates.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result beat: acc=%0b fast=%0b baud=%0d speed=%0d",
                             got.acc, got.fast, got.baud, got.speed);
            end
            else
            begin
                want = pending_rates.pop_front();
                if (got.acc !== want.acc || got.fast !== want.fast ||
                    got.baud !== want.baud || got.speed !== want.speed)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"result mismatch: expected acc=%0b fast=%0b baud=%0d ",
                                  "speed=%0d, got acc=%0b fast=%0b baud=%0d speed=%0d"},
                                 want.acc, want.fast, want.baud, want.speed,
                                 got.acc, got.fast, got.baud, got.speed);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("** baud_divisor_decoder: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [RATIO_W-1:0] base_ratios [6];
        logic [RATIO_W-1:0] fast_ratios [6];
        base_ratios = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd31, 5'd16};
        fast_ratios = '{5'd31, 5'd0, 5'd16, 5'd16, 5'd31, 5'd1};
        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        value_word <= '0;
        index_word <= '0;
        rsp_ready  <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        shadow_ratio_base = RATIO_RESET;
        shadow_ratio_fast = RATIO_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_PROBES; i++)
            send_request(probes[i].value, probes[i].index, probes[i].typed, probes[i].result);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            req_valid <= 1'b0;
            wait_for_drain();
            no_idle = 1'b0;
            if (ph < 6)
            begin
                write_ratio(ADDR_RATIO_BASE, base_ratios[ph]);
                write_ratio(ADDR_RATIO_FAST, fast_ratios[ph]);
            end
            else
            begin
                write_ratio(ADDR_RATIO_BASE, RATIO_W'($urandom_range(0, 31)));
                write_ratio(ADDR_RATIO_FAST, RATIO_W'($urandom_range(0, 31)));
            end
            // Phase 2 fills the pipeline against a long result stall; phase 4 runs flat out.
            if (ph == 2)
            begin
                no_idle = 1'b1;
                hold_pending = 1'b1;
            end
            else if (ph == 4)
            begin
                no_idle = 1'b1;
            end
            // Fastest rate on the fast clock saturates the speed at the top ratio.
            send_request(16'hC000, 16'h0200, 1'b0, '0);
            send_request(16'h0000, 16'h0000, 1'b0, '0);
            for (int k = 0; k < BEATS_PER_PHASE; k++)
                send_random_request();
        end

        req_valid <= 1'b0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("** baud_divisor_decoder: PASSED **");
        else
            $display("** baud_divisor_decoder: FAILED **");
        $finish;
    end

endmodule
